>>> rtl/core/skv_pkg.sv
// shared types and constants of the sectioned key/value text parser
`default_nettype none

package skv_pkg;

  // kind of one output item
  typedef enum logic [1:0] {
    KIND_SECTION = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_VALUE   = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] REG_SECTION_OPEN  = 3'd0;
  localparam logic [2:0] REG_SECTION_CLOSE = 3'd1;
  localparam logic [2:0] REG_KEY_OPEN      = 3'd2;
  localparam logic [2:0] REG_KV_SEPARATOR  = 3'd3;
  localparam logic [2:0] REG_RECORD_END    = 3'd4;

  localparam int unsigned ADDR_W = 5;

  typedef struct packed {
    logic [7:0] section_open;
    logic [7:0] section_close;
    logic [7:0] key_open;
    logic [7:0] key_value_separator;
    logic [7:0] record_end;
  } cfg_t;

  typedef struct packed {
    logic  clr_all;
    logic  clr_sec;
    logic  clr_key;
    logic  clr_val;
    logic  wr_sec;
    logic  wr_key;
    logic  wr_val;
    logic  idx_clr;
    logic  idx_inc;
    logic  out_load;
    kind_e sel;
    logic  out_err;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic hit_sec_open;
    logic hit_sec_close;
    logic hit_key_open;
    logic hit_kv_sep;
    logic hit_rec_end;
    logic sec_full;
    logic key_full;
    logic val_full;
    logic idx_end;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/skv_if.sv
// input and output channel interfaces of the parser
`default_nettype none

interface skv_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] char_in;

  modport source (output valid, output restart, output char_in, input ready);
  modport sink (input valid, input restart, input char_in, output ready);
endinterface

interface skv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] char_out;
  logic       is_error;
  logic       last;

  modport source (output valid, output item_kind, output char_out, output is_error,
                  output last, input ready);
  modport sink (input valid, input item_kind, input char_out, input is_error,
                input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/skv_cfg.sv
// apb register file holding the delimiter characters
`default_nettype none

module skv_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [skv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output skv_pkg::cfg_t                   cfg_o
);
  import skv_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic [7:0] rd_byte;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.section_open        <= 8'd91;
      cfg_q.section_close       <= 8'd93;
      cfg_q.key_open            <= 8'd46;
      cfg_q.key_value_separator <= 8'd61;
      cfg_q.record_end          <= 8'd10;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SECTION_OPEN:  cfg_q.section_open        <= pwdata[7:0];
        REG_SECTION_CLOSE: cfg_q.section_close       <= pwdata[7:0];
        REG_KEY_OPEN:      cfg_q.key_open            <= pwdata[7:0];
        REG_KV_SEPARATOR:  cfg_q.key_value_separator <= pwdata[7:0];
        REG_RECORD_END:    cfg_q.record_end          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SECTION_OPEN:  rd_byte = cfg_q.section_open;
      REG_SECTION_CLOSE: rd_byte = cfg_q.section_close;
      REG_KEY_OPEN:      rd_byte = cfg_q.key_open;
      REG_KV_SEPARATOR:  rd_byte = cfg_q.key_value_separator;
      REG_RECORD_END:    rd_byte = cfg_q.record_end;
      default:           rd_byte = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_byte};
  assign cfg_o  = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/skv_dp.sv
// datapath: string stores, fill counts, replay index and output register
`default_nettype none

module skv_dp #(
  parameter int unsigned SECTION_CHARS = 16,
  parameter int unsigned KEY_CHARS     = 16,
  parameter int unsigned VALUE_CHARS   = 31
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire skv_pkg::cfg_t    cfg_i,
  input  wire logic [7:0]       char_i,
  input  wire skv_pkg::cmd_t    cmd_i,
  output skv_pkg::status_t      status_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            out_kind_o,
  output logic [7:0]            out_char_o,
  output logic                  out_err_o,
  output logic                  out_last_o
);
  import skv_pkg::*;

  localparam int unsigned SEC_CW = $clog2(SECTION_CHARS + 1);
  localparam int unsigned KEY_CW = $clog2(KEY_CHARS + 1);
  localparam int unsigned VAL_CW = $clog2(VALUE_CHARS + 1);
  localparam int unsigned SEC_AW = (SECTION_CHARS > 1) ? $clog2(SECTION_CHARS) : 1;
  localparam int unsigned KEY_AW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
  localparam int unsigned VAL_AW = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;
  localparam int unsigned IDX_A  = (SEC_CW > KEY_CW) ? SEC_CW : KEY_CW;
  localparam int unsigned IDX_W  = (IDX_A > VAL_CW) ? IDX_A : VAL_CW;

  logic [7:0] sec_mem [SECTION_CHARS];
  logic [7:0] key_mem [KEY_CHARS];
  logic [7:0] val_mem [VALUE_CHARS];

  logic [SEC_CW-1:0] sec_count_q;
  logic [KEY_CW-1:0] key_count_q;
  logic [VAL_CW-1:0] val_count_q;
  logic [IDX_W-1:0]  idx_q;

  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_char_q;
  logic       out_err_q;
  logic       out_last_q;

  logic [IDX_W-1:0] sel_count;

  // store writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sec) begin
      sec_mem[sec_count_q[SEC_AW-1:0]] <= char_i;
    end
    if (cmd_i.wr_key) begin
      key_mem[key_count_q[KEY_AW-1:0]] <= char_i;
    end
    if (cmd_i.wr_val) begin
      val_mem[val_count_q[VAL_AW-1:0]] <= char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_count_q <= '0;
      key_count_q <= '0;
      val_count_q <= '0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.clr_all || cmd_i.clr_sec) begin
        sec_count_q <= '0;
      end else if (cmd_i.wr_sec) begin
        sec_count_q <= sec_count_q + 1'b1;
      end
      if (cmd_i.clr_all || cmd_i.clr_key) begin
        key_count_q <= '0;
      end else if (cmd_i.wr_key) begin
        key_count_q <= key_count_q + 1'b1;
      end
      if (cmd_i.clr_all || cmd_i.clr_val) begin
        val_count_q <= '0;
      end else if (cmd_i.wr_val) begin
        val_count_q <= val_count_q + 1'b1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // registered store read at the replay index
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.sel;
      out_err_q  <= cmd_i.out_err;
      out_last_q <= cmd_i.out_last;
      case (cmd_i.sel)
        KIND_SECTION: out_char_q <= sec_mem[idx_q[SEC_AW-1:0]];
        KIND_KEY:     out_char_q <= key_mem[idx_q[KEY_AW-1:0]];
        KIND_VALUE:   out_char_q <= val_mem[idx_q[VAL_AW-1:0]];
        default:      out_char_q <= 8'd0;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.sel)
      KIND_SECTION: sel_count = IDX_W'(sec_count_q);
      KIND_KEY:     sel_count = IDX_W'(key_count_q);
      KIND_VALUE:   sel_count = IDX_W'(val_count_q);
      default:      sel_count = '0;
    endcase
  end

  always_comb begin
    status_o.hit_sec_open  = (char_i == cfg_i.section_open);
    status_o.hit_sec_close = (char_i == cfg_i.section_close);
    status_o.hit_key_open  = (char_i == cfg_i.key_open);
    status_o.hit_kv_sep    = (char_i == cfg_i.key_value_separator);
    status_o.hit_rec_end   = (char_i == cfg_i.record_end);
    status_o.sec_full      = (sec_count_q == SEC_CW'(SECTION_CHARS));
    status_o.key_full      = (key_count_q == KEY_CW'(KEY_CHARS));
    status_o.val_full      = (val_count_q == VAL_CW'(VALUE_CHARS));
    status_o.idx_end       = (idx_q == sel_count);
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_char_o  = out_char_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/skv_ctrl.sv
// controller: parse mode machine and record replay sequencer
`default_nettype none

module skv_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             restart_i,
  output logic                  in_ready_o,
  input  wire skv_pkg::status_t status_i,
  output skv_pkg::cmd_t         cmd_o
);
  import skv_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEC  = 3'd1;
  localparam logic [2:0] ST_KEY  = 3'd2;
  localparam logic [2:0] ST_VAL  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;

  // parse modes
  localparam logic [2:0] MODE_SEARCH  = 3'd0;
  localparam logic [2:0] MODE_SECTION = 3'd1;
  localparam logic [2:0] MODE_KEY     = 3'd2;
  localparam logic [2:0] MODE_VALUE   = 3'd3;
  localparam logic [2:0] MODE_ERROR   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] mode_q, mode_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_SEARCH;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.sel = KIND_END;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            cmd_o.clr_all = 1'b1;
            mode_d        = MODE_SEARCH;
          end else begin
            case (mode_q)
              MODE_SEARCH: begin
                if (status_i.hit_sec_open) begin
                  cmd_o.clr_sec = 1'b1;
                  mode_d        = MODE_SECTION;
                end else if (status_i.hit_key_open) begin
                  mode_d = MODE_KEY;
                end
              end
              MODE_SECTION: begin
                if (status_i.hit_sec_close) begin
                  mode_d = MODE_SEARCH;
                end else if (status_i.sec_full) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_err  = 1'b1;
                  cmd_o.out_last = 1'b1;
                  mode_d         = MODE_ERROR;
                end else begin
                  cmd_o.wr_sec = 1'b1;
                end
              end
              MODE_KEY: begin
                if (status_i.hit_kv_sep) begin
                  mode_d = MODE_VALUE;
                end else if (status_i.hit_rec_end) begin
                  // key without value: replay with an empty value
                  cmd_o.clr_val = 1'b1;
                  cmd_o.idx_clr = 1'b1;
                  mode_d        = MODE_SEARCH;
                  state_d       = ST_SEC;
                end else if (status_i.key_full) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_err  = 1'b1;
                  cmd_o.out_last = 1'b1;
                  mode_d         = MODE_ERROR;
                end else begin
                  cmd_o.wr_key = 1'b1;
                end
              end
              MODE_VALUE: begin
                if (status_i.hit_rec_end) begin
                  cmd_o.idx_clr = 1'b1;
                  mode_d        = MODE_SEARCH;
                  state_d       = ST_SEC;
                end else if (status_i.val_full) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_err  = 1'b1;
                  cmd_o.out_last = 1'b1;
                  mode_d         = MODE_ERROR;
                end else begin
                  cmd_o.wr_val = 1'b1;
                end
              end
              default: begin
                mode_d = MODE_ERROR;
              end
            endcase
          end
        end
      end
      ST_SEC: begin
        cmd_o.sel = KIND_SECTION;
        if (status_i.idx_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_KEY;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      ST_KEY: begin
        cmd_o.sel = KIND_KEY;
        if (status_i.idx_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_VAL;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      ST_VAL: begin
        cmd_o.sel = KIND_VALUE;
        if (status_i.idx_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_END;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.idx_inc  = 1'b1;
        end
      end
      ST_END: begin
        cmd_o.sel = KIND_END;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.clr_key  = 1'b1;
          cmd_o.clr_val  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/sectioned_key_value_text_parser.sv
// Sectioned key/value text parser, top level.
// The in_i channel carries one text byte per beat (char_in) or a restart
// request; out_o carries the items of a finished record: section bytes, key
// bytes, value bytes, then one record-end item with last set. An overflowing
// store sends a single record-end item with is_error and last set, after
// which bytes are dropped until a restart beat.
// A record-end byte starts a replay, and the next beat is not taken until
// the replay is through: the replay sequencer reads the stores one byte per
// cycle, while the output register is free, through a single output register,
// and takes a separate step to switch from one store to the next.
// The first result item shows on out_o in the cycle after it is read.
// When the receiver stalls, the output register holds its item and the
// replay waits; input beats are not taken until the output register frees.
// Delimiters are set over the apb port (registers at byte offsets 0 to 16).
// Reset sets the delimiters to '[', ']', '.', '=' and newline, empties the
// stores and puts the parser in the search mode.
`default_nettype none

module sectioned_key_value_text_parser #(
  parameter int unsigned SECTION_CHARS = 16,
  parameter int unsigned KEY_CHARS     = 16,
  parameter int unsigned VALUE_CHARS   = 31
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  skv_in_if.sink                          in_i,
  skv_out_if.source                       out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [skv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import skv_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  skv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  skv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .restart_i  (in_i.restart),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  skv_dp #(
    .SECTION_CHARS (SECTION_CHARS),
    .KEY_CHARS     (KEY_CHARS),
    .VALUE_CHARS   (VALUE_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .char_i      (in_i.char_in),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_kind_o  (out_o.item_kind),
    .out_char_o  (out_o.char_out),
    .out_err_o   (out_o.is_error),
    .out_last_o  (out_o.last)
  );

endmodule

`default_nettype wire

>>> test/skv_record_checker.sv
// scoreboard that predicts the parser's record items and checks every output beat
`default_nettype none

module skv_record_checker #(
  parameter int unsigned SECTION_CHARS = 16,
  parameter int unsigned KEY_CHARS     = 16,
  parameter int unsigned VALUE_CHARS   = 31
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic                       in_restart_i,
  input  wire logic [7:0]                 in_char_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [1:0]                 out_kind_i,
  input  wire logic [7:0]                 out_char_i,
  input  wire logic                       out_err_i,
  input  wire logic                       out_last_i,
  input  wire logic                       psel_i,
  input  wire logic                       penable_i,
  input  wire logic                       pwrite_i,
  input  wire logic                       pready_i,
  input  wire logic [skv_pkg::ADDR_W-1:0] paddr_i,
  input  wire logic [31:0]                pwdata_i,
  output int                              mismatches_o,
  output int                              waiting_o,
  output int                              results_o,
  output int                              overflows_o
);
  import skv_pkg::*;

  typedef enum logic [2:0] {
    MODE_SEARCH,
    MODE_SECTION,
    MODE_KEY,
    MODE_VALUE,
    MODE_ERROR
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       err;
    logic       last;
  } item_t;

  // '[' ']' '.' '=' newline
  localparam cfg_t DELIM_RESET = '{8'h5B, 8'h5D, 8'h2E, 8'h3D, 8'h0A};

  mode_e       mode;
  cfg_t        delim;
  logic [7:0]  section_mem [SECTION_CHARS];
  logic [7:0]  key_mem [KEY_CHARS];
  logic [7:0]  value_mem [VALUE_CHARS];
  int unsigned section_len, key_len, value_len;
  item_t       expected_q [$];
  item_t       want;

  function automatic void expect_item(kind_e k, logic [7:0] c, logic e, logic l);
    item_t it;
    it.kind = k;
    it.ch   = c;
    it.err  = e;
    it.last = l;
    expected_q.insert(expected_q.size(), it);
  endfunction

  function automatic void enter_error();
    mode = MODE_ERROR;
    overflows_o++;
    expect_item(KIND_END, 8'h00, 1'b1, 1'b1);
  endfunction

  // replay the stored strings, then back to search with key and value emptied
  function automatic void close_record();
    for (int unsigned i = 0; i < section_len; i++) begin
      expect_item(KIND_SECTION, section_mem[i], 1'b0, 1'b0);
    end
    for (int unsigned i = 0; i < key_len; i++) begin
      expect_item(KIND_KEY, key_mem[i], 1'b0, 1'b0);
    end
    for (int unsigned i = 0; i < value_len; i++) begin
      expect_item(KIND_VALUE, value_mem[i], 1'b0, 1'b0);
    end
    expect_item(KIND_END, 8'h00, 1'b0, 1'b1);
    key_len   = 0;
    value_len = 0;
    mode      = MODE_SEARCH;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches_o++;
    if (mismatches_o <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode         = MODE_SEARCH;
      delim        = DELIM_RESET;
      section_len  = 0;
      key_len      = 0;
      value_len    = 0;
      expected_q.delete();
      mismatches_o = 0;
      results_o    = 0;
      overflows_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          note_mismatch($sformatf("unexpected beat kind %0d char %02h err %b last %b",
                                  out_kind_i, out_char_i, out_err_i, out_last_i));
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (out_kind_i !== want.kind || out_char_i !== want.ch ||
              out_err_i !== want.err || out_last_i !== want.last) begin
            note_mismatch($sformatf({"beat %0d expected kind %0d char %02h err %b last %b,",
                                     " got kind %0d char %02h err %b last %b"},
                                    results_o, want.kind, want.ch, want.err, want.last,
                                    out_kind_i, out_char_i, out_err_i, out_last_i));
          end
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_SECTION_OPEN:  delim.section_open        = pwdata_i[7:0];
          REG_SECTION_CLOSE: delim.section_close       = pwdata_i[7:0];
          REG_KEY_OPEN:      delim.key_open            = pwdata_i[7:0];
          REG_KV_SEPARATOR:  delim.key_value_separator = pwdata_i[7:0];
          REG_RECORD_END:    delim.record_end          = pwdata_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (in_restart_i) begin
          mode        = MODE_SEARCH;
          section_len = 0;
          key_len     = 0;
          value_len   = 0;
        end else begin
          case (mode)
            MODE_SEARCH: begin
              // section open wins when both openers are the same byte
              if (in_char_i == delim.section_open) begin
                section_len = 0;
                mode        = MODE_SECTION;
              end else if (in_char_i == delim.key_open) begin
                mode = MODE_KEY;
              end
            end
            MODE_SECTION: begin
              if (in_char_i == delim.section_close) begin
                mode = MODE_SEARCH;
              end else if (section_len >= SECTION_CHARS) begin
                enter_error();
              end else begin
                section_mem[section_len] = in_char_i;
                section_len++;
              end
            end
            MODE_KEY: begin
              // separator wins when it equals the record end
              if (in_char_i == delim.key_value_separator) begin
                mode = MODE_VALUE;
              end else if (in_char_i == delim.record_end) begin
                value_len = 0;
                close_record();
              end else if (key_len >= KEY_CHARS) begin
                enter_error();
              end else begin
                key_mem[key_len] = in_char_i;
                key_len++;
              end
            end
            MODE_VALUE: begin
              if (in_char_i == delim.record_end) begin
                close_record();
              end else if (value_len >= VALUE_CHARS) begin
                enter_error();
              end else begin
                value_mem[value_len] = in_char_i;
                value_len++;
              end
            end
            default: mode = MODE_ERROR;
          endcase
        end
      end
    end
    waiting_o = expected_q.size();
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// parser testbench top: clock, reset, delimiter setup, text stimulus and verdict
`default_nettype none

module tb_top;
  import skv_pkg::*;

  localparam int unsigned SECTION_CHARS = 16;
  localparam int unsigned KEY_CHARS     = 16;
  localparam int unsigned VALUE_CHARS   = 31;
  localparam int unsigned HOLD_CYCLES   = 300;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  wire logic [31:0]  prdata;
  wire logic         pready;

  skv_in_if  char_ch ();
  skv_out_if item_ch ();

  cfg_t delims;
  int   send_idle_pct, recv_idle_pct;
  int   beats_sent;
  int   hold_asks, hold_seen, hold_left;
  int   mismatches, waiting, results, overflows;

  always #10 clk_i = ~clk_i;

  sectioned_key_value_text_parser uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_ch),
    .out_o   (item_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  skv_record_checker #(
    .SECTION_CHARS (SECTION_CHARS),
    .KEY_CHARS     (KEY_CHARS),
    .VALUE_CHARS   (VALUE_CHARS)
  ) record_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (char_ch.valid),
    .in_ready_i   (char_ch.ready),
    .in_restart_i (char_ch.restart),
    .in_char_i    (char_ch.char_in),
    .out_valid_i  (item_ch.valid),
    .out_ready_i  (item_ch.ready),
    .out_kind_i   (item_ch.item_kind),
    .out_char_i   (item_ch.char_out),
    .out_err_i    (item_ch.is_error),
    .out_last_i   (item_ch.last),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .results_o    (results),
    .overflows_o  (overflows)
  );

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      item_ch.ready <= 1'b0;
    end else begin
      item_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(input logic restart, input logic [7:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_ch.valid   <= 1'b1;
    char_ch.restart <= restart;
    char_ch.char_in <= ch;
    @(posedge clk_i);
    while (!char_ch.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // back-to-back apb writes keep psel high; the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic apply_delims(input cfg_t d);
    write_reg(REG_SECTION_OPEN, d.section_open);
    write_reg(REG_SECTION_CLOSE, d.section_close);
    write_reg(REG_KEY_OPEN, d.key_open);
    write_reg(REG_KV_SEPARATOR, d.key_value_separator);
    write_reg(REG_RECORD_END, d.record_end);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    delims = d;
  endtask

  // stop sending and wait until every predicted item has come out
  task automatic drain(input int unsigned tail);
    char_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic logic [7:0] text_byte(input logic [7:0] stop_a, input logic [7:0] stop_b);
    logic [7:0] c;
    do c = 8'($urandom); while (c == stop_a || c == stop_b);
    return c;
  endfunction

  // mostly short strings, sometimes full, sometimes one past full
  function automatic int unsigned pick_len(input int unsigned cap, input int unsigned usual);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return cap + 1;
    else if (r == 1) return cap;
    else return $urandom_range(0, usual);
  endfunction

  task automatic send_section(input int unsigned n);
    send_beat(1'b0, delims.section_open);
    repeat (n) send_beat(1'b0, text_byte(delims.section_close, delims.section_close));
    send_beat(1'b0, delims.section_close);
  endtask

  task automatic send_key_record(input int unsigned kn, input bit with_value,
                                 input int unsigned vn);
    send_beat(1'b0, delims.key_open);
    repeat (kn) send_beat(1'b0, text_byte(delims.key_value_separator, delims.record_end));
    if (with_value) begin
      send_beat(1'b0, delims.key_value_separator);
      repeat (vn) send_beat(1'b0, text_byte(delims.record_end, delims.record_end));
    end
    send_beat(1'b0, delims.record_end);
  endtask

  task automatic send_random_unit();
    int unsigned pick, kn, vn;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_beat(1'b1, 8'($urandom));
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 4)) send_beat(1'b0, 8'($urandom));
    end else if (pick < 35) begin
      kn = pick_len(SECTION_CHARS, 6);
      send_section(kn);
      if (kn > SECTION_CHARS) send_beat(1'b1, 8'($urandom));
    end else begin
      kn = pick_len(KEY_CHARS, 6);
      vn = pick_len(VALUE_CHARS, 8);
      send_key_record(kn, $urandom_range(0, 3) != 0, vn);
      // leave the latched error state again whenever a length is past its store
      if (kn > KEY_CHARS || vn > VALUE_CHARS) send_beat(1'b1, 8'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned stop;
    stop = beats_sent + beats;
    while (beats_sent < stop) send_random_unit();
  endtask

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    cfg_t       spread;
    logic [7:0] pick;
    bit         taken [256];
    string      opening;
    char_ch.valid   <= 1'b0;
    char_ch.restart <= 1'b0;
    char_ch.char_in <= 8'h00;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    delims        = '{8'h5B, 8'h5D, 8'h2E, 8'h3D, 8'h0A};
    send_idle_pct = 7;
    recv_idle_pct = 88;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset delimiters: skipped byte, section, full record, key without value,
    // restart, empty key and value, then extreme byte values
    opening = "x[ab].k=v\n.q\n";
    for (int i = 0; i < opening.len(); i++) send_beat(1'b0, opening[i]);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, ".");
    send_beat(1'b0, "=");
    send_beat(1'b0, "\n");
    send_beat(1'b0, ".");
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, "=");
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, "\n");
    drain(10);

    // extreme delimiter values; longest record under a long receiver hold-off
    apply_delims('{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF});
    hold_asks++;
    send_section(SECTION_CHARS);
    send_key_record(KEY_CHARS, 1'b1, VALUE_CHARS);
    send_key_record(2, 1'b1, VALUE_CHARS + 1);
    send_beat(1'b0, 8'($urandom));
    send_beat(1'b0, delims.record_end);
    send_beat(1'b1, 8'h00);
    run_random(15);
    drain(10);

    // separator equal to record end
    send_idle_pct = 88;
    recv_idle_pct = 7;
    apply_delims('{8'h3C, 8'h3E, 8'h5B, 8'h3B, 8'h3B});
    run_random(15);
    drain(10);

    // random distinct delimiters, no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 5; i++) begin
      do pick = 8'($urandom); while (taken[pick]);
      taken[pick] = 1'b1;
      spread = {spread[31:0], pick};
    end
    apply_delims(spread);
    run_random(15);
    drain(10);

    // section and key opened by the same byte
    apply_delims('{8'h7B, 8'h7D, 8'h7B, 8'h3D, 8'h0A});
    run_random(10);
    drain(80);

    $display("run covered %0d input beats over five delimiter settings", beats_sent);
    $display("%0d items checked, %0d overflows", results, overflows);
    if (mismatches == 0 && waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
